@@ src/lhrb_pkg.sv @@
`default_nettype none
package lhrb_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int AGE_W  = 4;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_COMMIT,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CHAR_W-1:0] ch;
    logic [AGE_W-1:0]  age;
    logic [POS_W-1:0]  pos;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctrl_t;

endpackage
`default_nettype wire

@@ src/lhrb_front.sv @@
`default_nettype none
module lhrb_front
  import lhrb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  output queue_head_t                head,
  input  wire back_ctrl_t            ctrl
);

  item_t      q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.ch  = s_tdata[9:2];
    dec.age = s_tdata[13:10];
    dec.pos = s_tdata[20:14];
    case (s_tdata[1:0])
      CMD_APPEND: dec.op = OP_APPEND;
      CMD_COMMIT: dec.op = OP_COMMIT;
      CMD_READ:   dec.op = OP_READ;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign s_tready   = (count != 2'd2) && !ctrl.clearing;
  assign push       = s_tvalid && s_tready;
  assign pop        = ctrl.pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ src/lhrb_back.sv @@
`default_nettype none
module lhrb_back
  import lhrb_pkg::*;
#(
  parameter int HIST_BYTES = 256,
  parameter int HIST_SLOTS = 16,
  parameter int MAX_LINE   = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire queue_head_t            head,
  output back_ctrl_t                  ctrl,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  localparam int LINE_CAP = (MAX_LINE < HIST_BYTES) ? MAX_LINE : (HIST_BYTES - 1);
  localparam int AW  = $clog2(HIST_BYTES);
  localparam int SW  = $clog2(HIST_SLOTS);
  localparam int LW  = $clog2(LINE_CAP + 1);
  localparam int LIW = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int PW  = AW + 2;

  typedef enum logic [10:0] {
    ST_CLEAR    = 11'b00000000001,
    ST_IDLE     = 11'b00000000010,
    ST_A_CMP    = 11'b00000000100,
    ST_R_ADDR   = 11'b00000001000,
    ST_R_DATA   = 11'b00000010000,
    ST_C_DUP    = 11'b00000100000,
    ST_C_EV_RD  = 11'b00001000000,
    ST_C_EV_CHK = 11'b00010000000,
    ST_C_CP_RD  = 11'b00100000000,
    ST_C_CP_WR  = 11'b01000000000,
    ST_C_TERM   = 11'b10000000000
  } state_t;

  state_t            state;
  item_t             cur;
  logic [SW-1:0]     oldest;
  logic [SW-1:0]     next_s;
  logic [AW:0]       wp;
  logic [LW-1:0]     staged_len;
  logic              match_newest;
  logic [AW-1:0]     newest_start;
  logic              wrap_ph;
  logic [LW-1:0]     idx;
  logic [AW-1:0]     clr_addr;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic              out_stored;
  logic [CHAR_W-1:0] out_byte;
  logic [CNT_W-1:0]  out_count;

  logic [CHAR_W-1:0] hist_mem [HIST_BYTES];
  logic [AW-1:0]     ent_mem  [HIST_SLOTS];
  logic [CHAR_W-1:0] stg_mem  [LINE_CAP];
  logic [CHAR_W-1:0] hist_rd;
  logic [AW-1:0]     ent_rd;
  logic [CHAR_W-1:0] stg_rd;

  logic              hist_we;
  logic [AW-1:0]     hist_wa;
  logic [CHAR_W-1:0] hist_wd;
  logic [AW-1:0]     hist_ra;
  logic              ent_we;
  logic [SW-1:0]     ent_wa;
  logic [SW-1:0]     ent_ra;
  logic              stg_we;
  logic [LIW-1:0]    stg_ra;

  logic              take;
  logic [SW-1:0]     held;
  logic [SW-1:0]     held_after;
  logic [SW-1:0]     slot_age;
  logic [PW-1:0]     app_sum;
  logic [PW-1:0]     rd_sum;
  logic [PW-1:0]     span_end;
  logic              wrap_needed;
  logic              collides;
  logic [31:0]       held_ext;
  int                age_tmp;
  int                held_tmp;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    if (s == SW'(HIST_SLOTS - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  always_comb begin
    held_tmp = int'(next_s) - int'(oldest);
    if (held_tmp < 0) begin
      held_tmp = held_tmp + HIST_SLOTS;
    end
    held       = SW'(held_tmp);
    held_after = (held == SW'(HIST_SLOTS - 1)) ? held : held + 1'b1;
    age_tmp    = int'(next_s) + HIST_SLOTS - 1 - int'(head.item.age);
    if (age_tmp >= HIST_SLOTS) begin
      age_tmp = age_tmp - HIST_SLOTS;
    end
    slot_age    = SW'(age_tmp);
    app_sum     = PW'(newest_start) + PW'(staged_len);
    rd_sum      = PW'(ent_rd) + PW'(cur.pos);
    span_end    = PW'(wp) + PW'(staged_len);
    wrap_needed = span_end >= PW'(HIST_BYTES);
    collides    = (PW'(wp) <= PW'(ent_rd)) && (span_end >= PW'(ent_rd));
    held_ext    = 32'(held);
  end

  assign take = (state == ST_IDLE) && head.valid && !out_valid;

  assign ctrl.pop      = take;
  assign ctrl.clearing = (state == ST_CLEAR);

  // memory port steering
  always_comb begin
    hist_we = 1'b0;
    hist_wa = '0;
    hist_wd = '0;
    hist_ra = app_sum[AW-1:0];
    ent_we  = 1'b0;
    ent_wa  = next_s;
    ent_ra  = oldest;
    stg_we  = 1'b0;
    stg_ra  = idx[LIW-1:0];
    case (state)
      ST_CLEAR: begin
        hist_we = 1'b1;
        hist_wa = clr_addr;
      end
      ST_IDLE: begin
        ent_ra = slot_age;
        stg_we = take && (head.item.op == OP_APPEND) && (staged_len < LW'(LINE_CAP));
      end
      ST_R_ADDR: begin
        hist_ra = rd_sum[AW-1:0];
      end
      ST_C_CP_WR: begin
        hist_we = 1'b1;
        hist_wa = AW'(wp + (AW + 1)'(idx));
        hist_wd = stg_rd;
      end
      ST_C_TERM: begin
        hist_we = 1'b1;
        hist_wa = span_end[AW-1:0];
        ent_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= wp[AW-1:0];
    end
    ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (stg_we) begin
      stg_mem[staged_len[LIW-1:0]] <= head.item.ch;
    end
    stg_rd <= stg_mem[stg_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      oldest       <= '0;
      next_s       <= '0;
      wp           <= '0;
      staged_len   <= '0;
      match_newest <= 1'b1;
      newest_start <= '0;
      wrap_ph      <= 1'b0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(HIST_BYTES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            cur        <= head.item;
            out_status <= STAT_OK;
            out_stored <= 1'b0;
            out_byte   <= '0;
            out_count  <= held_ext[CNT_W-1:0];
            case (head.item.op)
              OP_APPEND: begin
                if (staged_len >= LW'(LINE_CAP)) begin
                  out_status <= STAT_TOO_LONG;
                  out_valid  <= 1'b1;
                end else begin
                  staged_len <= staged_len + 1'b1;
                  if (held == '0 || app_sum >= PW'(HIST_BYTES)) begin
                    match_newest <= 1'b0;
                    out_valid    <= 1'b1;
                  end else begin
                    state <= ST_A_CMP;
                  end
                end
              end
              OP_READ: begin
                if (int'(head.item.age) >= int'(held)) begin
                  out_status <= STAT_RANGE;
                  out_valid  <= 1'b1;
                end else begin
                  state <= ST_R_ADDR;
                end
              end
              OP_COMMIT: begin
                if (held != '0 && match_newest && app_sum < PW'(HIST_BYTES)) begin
                  state <= ST_C_DUP;
                end else begin
                  wrap_ph <= wrap_needed;
                  state   <= ST_C_EV_RD;
                end
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        ST_A_CMP: begin
          if (hist_rd != cur.ch) begin
            match_newest <= 1'b0;
          end
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_R_ADDR: begin
          if (rd_sum >= PW'(HIST_BYTES)) begin
            out_status <= STAT_RANGE;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            state <= ST_R_DATA;
          end
        end
        ST_R_DATA: begin
          out_byte  <= hist_rd;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_C_DUP: begin
          if (hist_rd == '0) begin
            staged_len   <= '0;
            match_newest <= 1'b1;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            wrap_ph <= wrap_needed;
            state   <= ST_C_EV_RD;
          end
        end
        ST_C_EV_RD, ST_C_EV_CHK: begin
          if (state == ST_C_EV_RD && held != '0) begin
            state <= ST_C_EV_CHK;
          end else if (state == ST_C_EV_CHK && collides) begin
            oldest <= slot_inc(oldest);
            state  <= ST_C_EV_RD;
          end else if (wrap_ph) begin
            wp      <= '0;
            wrap_ph <= 1'b0;
            state   <= ST_C_EV_RD;
          end else begin
            idx   <= '0;
            state <= (staged_len == '0) ? ST_C_TERM : ST_C_CP_RD;
          end
        end
        ST_C_CP_RD: begin
          state <= ST_C_CP_WR;
        end
        ST_C_CP_WR: begin
          idx <= idx + 1'b1;
          if (idx + 1'b1 == staged_len) begin
            state <= ST_C_TERM;
          end else begin
            state <= ST_C_CP_RD;
          end
        end
        ST_C_TERM: begin
          wp           <= (AW + 1)'(span_end + PW'(1));
          next_s       <= slot_inc(next_s);
          newest_start <= wp[AW-1:0];
          if (slot_inc(next_s) == oldest) begin
            oldest <= slot_inc(oldest);
          end
          staged_len   <= '0;
          match_newest <= 1'b1;
          out_stored   <= 1'b1;
          out_count    <= CNT_W'(32'(held_after));
          out_valid    <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_count, out_byte, out_stored, out_status};

endmodule
`default_nettype wire

@@ src/line_history_ring_buffer_unit.sv @@
// commit: duplicate check, eviction, copy of staged characters, terminator write
// one item in the back end at a time, none taken while a result waits to be sent
// a two-beat queue in front, one output register
// reset: synchronous, then a clearing pass that zeroes each byte of the byte store
// during which no input beat is taken
`default_nettype none
module line_history_ring_buffer_unit
  import lhrb_pkg::*;
#(
  parameter int HIST_BYTES = 256,
  parameter int HIST_SLOTS = 16,
  parameter int MAX_LINE   = 128
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // command, char_byte, entry_offset, byte_position
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status, stored, read_byte, entry_count
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  queue_head_t head;
  back_ctrl_t  ctrl;

  lhrb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .head     (head),
    .ctrl     (ctrl)
  );

  lhrb_back #(
    .HIST_BYTES (HIST_BYTES),
    .HIST_SLOTS (HIST_SLOTS),
    .MAX_LINE   (MAX_LINE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .ctrl     (ctrl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import lhrb_pkg::*;

  localparam int NBYTES = 256;
  localparam int NSLOTS = 16;
  localparam int LCAP = 128;
  localparam int WDOG_LIMIT = 20000;

  // first member in the highest bits, status lands in the lowest
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [7:0]        rbyte;
    logic              stored;
    logic [STAT_W-1:0] status;
  } hist_result_t;

  // history predictor and store of expected results
  class history_scoreboard;
    logic [7:0] mem [NBYTES];
    int starts [NSLOTS];
    int head_slot, tail_slot, wpos, slen;
    logic [7:0] line [LCAP];
    bit same_as_newest;
    hist_result_t pending[$];
    int errors, checked, commits_stored;

    function void clear();
      foreach (mem[i]) mem[i] = '0;
      foreach (starts[i]) starts[i] = 0;
      head_slot = 0; tail_slot = 0; wpos = 0; slen = 0;
      same_as_newest = 1;
    endfunction

    function int held();
      return (tail_slot + NSLOTS - head_slot) % NSLOTS;
    endfunction

    function int slot_age(int age);
      return (tail_slot + 2 * NSLOTS - age - 1) % NSLOTS;
    endfunction

    function bit hits_oldest(int len);
      int s;
      if (held() == 0) return 0;
      s = starts[head_slot];
      return wpos <= s && wpos + len >= s;
    endfunction

    function void drop_overlap(int len);
      while (hits_oldest(len)) head_slot = (head_slot + 1) % NSLOTS;
    endfunction

    function bit store_line();
      int len, a;
      bit dup;
      len = slen;
      dup = 0;
      if (held() != 0 && same_as_newest) begin
        a = starts[slot_age(0)] + len;
        if (a < NBYTES && mem[a] == 8'd0) dup = 1;
      end
      slen = 0;
      same_as_newest = 1;
      if (dup) return 0;
      if (wpos + len >= NBYTES) begin
        drop_overlap(len);
        wpos = 0;
      end
      drop_overlap(len);
      for (int i = 0; i < len; i++) mem[wpos + i] = line[i];
      mem[wpos + len] = 8'd0;
      starts[tail_slot] = wpos;
      wpos += len + 1;
      tail_slot = (tail_slot + 1) % NSLOTS;
      if (tail_slot == head_slot) head_slot = (head_slot + 1) % NSLOTS;
      return 1;
    endfunction

    function void note_input(item_t it);
      hist_result_t r;
      int a;
      r = '0;
      case (it.op)
        OP_APPEND: begin
          if (slen >= LCAP) r.status = STAT_TOO_LONG;
          else begin
            a = (held() == 0) ? NBYTES : starts[slot_age(0)] + slen;
            if (a >= NBYTES || mem[a] != it.ch) same_as_newest = 0;
            line[slen] = it.ch;
            slen++;
          end
        end
        OP_COMMIT: begin
          r.stored = store_line();
          commits_stored += r.stored;
        end
        OP_READ: begin
          if (it.age >= held()) r.status = STAT_RANGE;
          else begin
            a = starts[slot_age(it.age)] + it.pos;
            if (a >= NBYTES) r.status = STAT_RANGE;
            else r.rbyte = mem[a];
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(held());
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      hist_result_t got, want;
      got = hist_result_t'(d[STAT_W+1+8+CNT_W-1:0]);
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", d);
        return;
      end
      want = pending.pop_front();
      if (got != want || d[OUT_TDATA_W-1:STAT_W+1+8+CNT_W] != '0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected st=%0d sto=%0d b=%h n=%0d got st=%0d sto=%0d b=%h n=%0d",
                   want.status, want.stored, want.rbyte, want.count,
                   got.status, got.stored, got.rbyte, got.count);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  history_scoreboard sb;
  int send_idle_pct, recv_stall_pct, wdog, sent;
  item_t recent[$];

  always #5 clk = ~clk;

  line_history_ring_buffer_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // tdata: command, char_byte, entry_offset, byte_position from bit 0 up
  function automatic logic [IN_TDATA_W-1:0] pack_item(item_t it);
    return {3'b0, it.pos, it.age, it.ch, it.op};
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pack_item(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(it);
    sent++;
  endtask

  task automatic send_op(op_t op, int ch, int age, int pos);
    item_t it;
    it.op = op; it.ch = CHAR_W'(ch); it.age = AGE_W'(age); it.pos = POS_W'(pos);
    send_item(it);
  endtask

  task automatic send_line(int len, bit repeat_newest);
    for (int i = 0; i < len; i++)
      send_op(OP_APPEND, repeat_newest ? sb.mem[(sb.starts[sb.slot_age(0)] + i) % NBYTES]
                                       : $urandom_range(1, 255), $urandom, 0);
    send_op(OP_COMMIT, $urandom, $urandom, $urandom);
  endtask

  task automatic random_phase(int n);
    int k, len;
    for (int i = 0; i < n; i += 0) begin
      k = $urandom_range(99);
      if (k < 45) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 135) : $urandom_range(0, 12);
        if (sb.held() > 0 && $urandom_range(4) == 0) len = 0;
        send_line(len, sb.held() > 0 && $urandom_range(5) == 0 && len < 20);
        i += len + 1;
      end else if (k < 85) begin
        send_op(OP_READ, $urandom, $urandom_range(0, sb.held() > 0 ? sb.held() : 15),
                $urandom_range(9) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 14));
        i++;
      end else begin
        send_op(op_t'($urandom_range(3)), $urandom, $urandom, $urandom);
        i++;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // directed
    send_op(OP_READ, 0, 0, 0);
    send_op(OP_COMMIT, 0, 0, 0);
    send_op(OP_COMMIT, 0, 0, 0);
    send_op(OP_NOP, 255, 15, 127);
    send_op(OP_APPEND, 8'hff, 15, 127);
    send_op(OP_APPEND, 8'h00, 0, 0);
    send_op(OP_COMMIT, 0, 0, 0);
    send_op(OP_APPEND, 8'hff, 0, 0);
    send_op(OP_APPEND, 8'h00, 0, 0);
    send_op(OP_COMMIT, 0, 0, 0);
    send_op(OP_APPEND, 8'hff, 0, 0);
    send_op(OP_COMMIT, 0, 0, 0);
    send_op(OP_READ, 0, 0, 0);
    send_op(OP_READ, 0, 1, 1);
    send_op(OP_READ, 0, 2, 127);
    send_op(OP_READ, 0, 15, 0);
    send_op(OP_READ, 0, 3, 0);
    // overflow the line limit once
    send_line(LCAP + 3, 0);
    send_op(OP_READ, 0, 0, 127);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle_pct = 74; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 74; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      random_phase(200);
    end
    s_tvalid <= 0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("sent %0d items, checked %0d results, %0d lines stored", sent, sb.checked,
             sb.commits_stored);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
